// File: rtl/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int VAL_W      = 32;
  localparam int FILL_W     = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_FRONT = 2'd2,
    CELL_FROM_BACK  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
  } cell_ctl_t;

endpackage

// File: rtl/deq_cell.sv
module deq_cell (
  input  logic                              clk,
  input  deq_pkg::cell_ctl_t                ctl,
  input  logic [deq_pkg::DATA_WIDTH-1:0]    load_data,
  input  logic [deq_pkg::DATA_WIDTH-1:0]    front_data,
  input  logic [deq_pkg::DATA_WIDTH-1:0]    back_data,
  output logic [deq_pkg::DATA_WIDTH-1:0]    data_o
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    unique case (ctl.cmd)
      CELL_LOAD:       data_nxt = load_data;
      CELL_FROM_FRONT: data_nxt = front_data;
      CELL_FROM_BACK:  data_nxt = back_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// File: rtl/double_ended_queue.sv
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle unless a held result is not taken; a front push
// or pop shifts every cell of the entry chain, a rear push loads one cell only.
// Reset: clears the fill count, output valid and status; cell contents are not
// cleared and are read only after being written.
module double_ended_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [deq_pkg::IN_DATA_W-1:0]      in_tdata,   // [31:0] push_value
  input  logic [1:0]                         in_tuser,   // [1:0] opcode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [deq_pkg::OUT_DATA_W-1:0]     out_tdata,  // [31:0] data_out, [36:32] fill_count
  output logic [1:0]                         out_tuser   // [1:0] status
);
  import deq_pkg::*;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [VAL_W-1:0]      out_data_r;
  logic [VAL_W-1:0]      out_data_nxt;
  status_t               out_status_r;
  status_t               out_status_nxt;
  logic [FILL_W-1:0]     out_fill_r;
  logic [FILL_W-1:0]     out_fill_nxt;

  logic                  in_acc;
  op_t                   op;
  logic [DATA_WIDTH-1:0] push_val;
  logic                  is_push;
  logic                  full;
  logic                  empty;
  logic                  do_push_rear;
  logic                  do_push_front;
  logic                  do_pop_front;
  logic                  do_pop_rear;
  logic [IDX_W-1:0]      rear_idx;

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  cell_ctl_t             cell_ctl [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign push_val  = DATA_WIDTH'(in_tdata[VAL_W-1:0]);
  assign is_push   = (op == OP_PUSH_REAR) || (op == OP_PUSH_FRONT);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign rear_idx  = IDX_W'(count_r - 1'b1);

  assign do_push_rear  = in_acc && (op == OP_PUSH_REAR) && !full;
  assign do_push_front = in_acc && (op == OP_PUSH_FRONT) && !full;
  assign do_pop_front  = in_acc && (op == OP_POP_FRONT) && !empty;
  assign do_pop_rear   = in_acc && (op == OP_POP_REAR) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] front_d;
    logic [DATA_WIDTH-1:0] back_d;

    if (i == 0) begin : g_head
      assign front_d = push_val;
    end else begin : g_body
      assign front_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign back_d = '0;
    end else begin : g_inner
      assign back_d = cell_q[i+1];
    end

    always_comb begin
      cell_ctl[i].cmd = CELL_HOLD;
      if (do_push_front) begin
        cell_ctl[i].cmd = (i == 0) ? CELL_LOAD : CELL_FROM_FRONT;
      end else if (do_pop_front) begin
        cell_ctl[i].cmd = CELL_FROM_BACK;
      end else if (do_push_rear && (count_r == CNT_W'(i))) begin
        cell_ctl[i].cmd = CELL_LOAD;
      end
    end

    deq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .load_data  (push_val),
      .front_data (front_d),
      .back_data  (back_d),
      .data_o     (cell_q[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    if (in_acc) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_status_nxt = ST_OK;
      if (is_push) begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          out_data_nxt = (op == OP_POP_FRONT) ? VAL_W'(cell_q[0]) : VAL_W'(cell_q[rear_idx]);
        end
      end
      out_fill_nxt = FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
    end else begin
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
    out_data_r <= out_data_nxt;
    out_fill_r <= out_fill_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_fill_r, out_data_r});
  assign out_tuser  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> out_fill_r == FILL_W'(DEPTH))
    else $error("full status without full fill count");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_EMPTY) |-> out_fill_r == '0)
    else $error("empty status with nonzero fill count");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push_rear || do_push_front) |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not advance fill count");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop_rear || do_pop_front) |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not drop fill count");

endmodule

// File: tb/tb_double_ended_queue.sv
`timescale 1ns / 100ps

module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int RANDOM_ITEMS = 1880;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    op_t         op;
    logic [31:0] value;
  } deque_op_t;

  typedef struct {
    logic [31:0]      data;
    status_t          status;
    logic [FILL_W-1:0] fill;
  } deque_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = OP_PUSH_REAR;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  deque_op_t     pending_ops[$];
  deque_result_t expected_results[$];

  logic [31:0]      ring_vals[DEPTH];
  logic [IDX_W-1:0] head_pos = '0;
  logic [CNT_W-1:0] held     = '0;

  int total_ops     = 0;
  int accepted_ops  = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic deque_result_t deque_apply(op_t op, logic [31:0] value);
    deque_result_t    res;
    logic [IDX_W-1:0] slot;
    res.data   = '0;
    res.status = ST_OK;
    if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
      if (held >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        if (op == OP_PUSH_REAR) begin
          slot = head_pos + held[IDX_W-1:0];
        end else begin
          head_pos = head_pos - 1'b1;
          slot     = head_pos;
        end
        ring_vals[slot] = value;
        held = held + 1'b1;
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        if (op == OP_POP_FRONT) begin
          res.data = ring_vals[head_pos];
          head_pos = head_pos + 1'b1;
        end else begin
          slot     = head_pos + held[IDX_W-1:0] - 1'b1;
          res.data = ring_vals[slot];
        end
        held = held - 1'b1;
      end
    end
    res.fill = held;
    return res;
  endfunction

  task automatic queue_op(op_t op, logic [31:0] value);
    deque_op_t item;
    item.op    = op;
    item.value = value;
    pending_ops.push_back(item);
    total_ops++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    int phase;
    phase = (total_ops == 0) ? 0 : (accepted_ops * 4) / total_ops;
    if (phase > 3) phase = 3;
    case (phase)
      0:       begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
      1:       begin send_idle_pct <= 52; recv_idle_pct <= 0;  end
      2:       begin send_idle_pct <= 0;  recv_idle_pct <= 52; end
      default: begin send_idle_pct <= 15; recv_idle_pct <= 15; end
    endcase
  end

  always @(posedge clk) begin
    deque_op_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_ops[0];
        pending_ops.delete(0);
        in_tvalid <= 1'b1;
        in_tdata  <= item.value;
        in_tuser  <= item.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(deque_apply(op_t'(in_tuser), in_tdata));
      accepted_ops++;
    end
  end

  always @(posedge clk) begin
    deque_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result data=%h status=%0d fill=%0d", $time,
                 out_tdata[31:0], out_tuser, out_tdata[36:32]);
        error_count++;
      end else begin
        exp_res = expected_results[0];
        expected_results.delete(0);
        if (out_tdata[31:0] !== exp_res.data) begin
          $display("%0t: data_out mismatch expected %h actual %h", $time,
                   exp_res.data, out_tdata[31:0]);
          error_count++;
        end
        if (out_tuser !== exp_res.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   exp_res.status, out_tuser);
          error_count++;
        end
        if (out_tdata[36:32] !== exp_res.fill) begin
          $display("%0t: fill_count mismatch expected %0d actual %0d", $time,
                   exp_res.fill, out_tdata[36:32]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int      burst_len;
    int      push_pct;
    int      made;
    op_t     op;

    queue_op(OP_POP_FRONT, 32'h0);
    queue_op(OP_POP_REAR, 32'hFFFF_FFFF);
    queue_op(OP_PUSH_REAR, 32'h7FFF_FFFF);
    queue_op(OP_PUSH_FRONT, 32'h8000_0000);
    queue_op(OP_POP_REAR, 32'h0);
    queue_op(OP_POP_FRONT, 32'h0);
    for (int i = 0; i < DEPTH; i++) begin
      queue_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR,
               (i % 4 == 0) ? 32'hFFFF_FFFF : (i % 4 == 1) ? 32'h0 : $urandom);
    end
    queue_op(OP_PUSH_REAR, 32'h1234_5678);
    queue_op(OP_PUSH_FRONT, 32'h8765_4321);
    queue_op(OP_POP_FRONT, 32'h0);
    queue_op(OP_POP_REAR, 32'h0);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      burst_len = $urandom_range(40, 4);
      case ($urandom_range(2))
        0:       push_pct = 78;
        1:       push_pct = 22;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < burst_len && made < RANDOM_ITEMS; i++) begin
        if ($urandom_range(99) < push_pct) begin
          op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        end else begin
          op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
        end
        queue_op(op, pick_value());
        made++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(negedge clk);
    end while (pending_ops.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
